@@ src/dpfr_pkg.sv @@
// Package for the demand page fault resolver: default sizes, codes, words
// and the command and status groups between controller and datapath.
// No dependencies.
package dpfr_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 8;
  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned MAX_PAGES_DEF    = 1024;

  localparam int unsigned LEN_W     = 23;
  localparam int unsigned ROW_SEL_W = 3;

  typedef enum logic [1:0] {
    ACT_STORED  = 2'd0,
    ACT_NO_SEG  = 2'd1,
    ACT_ALREADY = 2'd2,
    ACT_MAPPED  = 2'd3
  } action_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_FAULT = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SEARCH,
    S_PICK,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic [2:0]       seg_slot;
    logic [31:0]      new_base;
    logic [LEN_W-1:0] new_mem_len;
    logic [LEN_W-1:0] new_file_len;
    logic [31:0]      new_file_pos;
    logic [2:0]       new_perm;
    logic [31:0]      miss_addr;
  } req_word_t;

  typedef struct packed {
    action_t     action;
    logic [2:0]  hit_slot;
    logic [31:0] page_addr;
    logic [31:0] file_read_pos;
    logic [12:0] copy_bytes;
    logic [12:0] zero_bytes;
    logic [2:0]  page_perm;
  } rsp_word_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic search;
    logic pick;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ src/dpfr_if.sv @@
// Channel interfaces of the demand page fault resolver: request, response
// and configuration write. No dependencies.
interface dpfr_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  seg_slot;
  logic [31:0] new_base;
  logic [22:0] new_mem_len;
  logic [22:0] new_file_len;
  logic [31:0] new_file_pos;
  logic [2:0]  new_perm;
  logic [31:0] miss_addr;

  modport source (
    output valid, kind, seg_slot, new_base, new_mem_len, new_file_len,
    output new_file_pos, new_perm, miss_addr,
    input  ready
  );
  modport sink (
    input  valid, kind, seg_slot, new_base, new_mem_len, new_file_len,
    input  new_file_pos, new_perm, miss_addr,
    output ready
  );
endinterface

interface dpfr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  hit_slot;
  logic [31:0] page_addr;
  logic [31:0] file_read_pos;
  logic [12:0] copy_bytes;
  logic [12:0] zero_bytes;
  logic [2:0]  page_perm;

  modport source (
    output valid, action, hit_slot, page_addr, file_read_pos, copy_bytes,
    output zero_bytes, page_perm,
    input  ready
  );
  modport sink (
    input  valid, action, hit_slot, page_addr, file_read_pos, copy_bytes,
    input  zero_bytes, page_perm,
    output ready
  );
endinterface

interface dpfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ src/dpfr_ctrl.sv @@
// Controller of the demand page fault resolver: sequences load and fault
// words through the datapath. Depends on dpfr_pkg.
module dpfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  dpfr_pkg::kind_t   in_kind,
  output logic              in_ready,
  input  dpfr_pkg::status_t status,
  output dpfr_pkg::cmd_t    cmd
);

  dpfr_pkg::state_t state;
  dpfr_pkg::state_t state_next;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpfr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dpfr_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = (in_kind == dpfr_pkg::KIND_LOAD) ? dpfr_pkg::S_LOAD
                                                        : dpfr_pkg::S_SEARCH;
        end
      end
      dpfr_pkg::S_LOAD: begin
        if (status.out_free) begin
          state_next = dpfr_pkg::S_IDLE;
        end
      end
      dpfr_pkg::S_SEARCH: state_next = dpfr_pkg::S_PICK;
      dpfr_pkg::S_PICK:   state_next = dpfr_pkg::S_RESOLVE;
      dpfr_pkg::S_RESOLVE: begin
        if (status.out_free) begin
          state_next = dpfr_pkg::S_IDLE;
        end
      end
      default: state_next = dpfr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      dpfr_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      dpfr_pkg::S_LOAD:    cmd.load   = status.out_free;
      dpfr_pkg::S_SEARCH:  cmd.search = 1'b1;
      dpfr_pkg::S_PICK:    cmd.pick   = 1'b1;
      dpfr_pkg::S_RESOLVE: cmd.commit = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_fault_seq: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_kind == dpfr_pkg::KIND_FAULT) |=>
      (state == dpfr_pkg::S_SEARCH) ##1 (state == dpfr_pkg::S_PICK)
      ##1 (state == dpfr_pkg::S_RESOLVE))
    else $error("fault word left the search sequence");

  a_load_seq: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_kind == dpfr_pkg::KIND_LOAD) |=> (state == dpfr_pkg::S_LOAD))
    else $error("load word not routed to load state");

  a_result_gate: assert property (@(posedge clk) disable iff (rst)
    (cmd.load || cmd.commit) |-> status.out_free)
    else $error("result issued while output register busy");

endmodule

@@ src/dpfr_datapath.sv @@
// Datapath of the demand page fault resolver: descriptor table, range
// search, mapped-page bitmap memory and result register. Depends on dpfr_pkg.
module dpfr_datapath #(
  parameter int unsigned MAX_SEGMENTS = dpfr_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned PAGE_BYTES   = dpfr_pkg::PAGE_BYTES_DEF,
  parameter int unsigned MAX_PAGES    = dpfr_pkg::MAX_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dpfr_pkg::cmd_t      cmd,
  output dpfr_pkg::status_t   status,
  input  dpfr_pkg::req_word_t req_word,
  input  logic                cfg_wr,
  input  logic [3:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dpfr_pkg::rsp_word_t out_word
);

  localparam int unsigned LEN_W      = dpfr_pkg::LEN_W;
  localparam int unsigned ROW_SEL_W  = dpfr_pkg::ROW_SEL_W;
  localparam int unsigned SEG_W      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PIDX_W     = LEN_W - PAGE_SHIFT;
  localparam int unsigned PG_IDX_W   = $clog2(MAX_PAGES);
  localparam int unsigned BIT_SEL_W  = PG_IDX_W - ROW_SEL_W;
  localparam int unsigned ROW_BITS   = 1 << BIT_SEL_W;
  localparam int unsigned ROWS       = MAX_SEGMENTS << ROW_SEL_W;
  localparam int unsigned ADDR_W     = SEG_W + ROW_SEL_W;

  dpfr_pkg::req_word_t item;
  logic [3:0]          seg_count;

  logic [31:0]      base_tab  [MAX_SEGMENTS];
  logic [LEN_W-1:0] mlen_tab  [MAX_SEGMENTS];
  logic [LEN_W-1:0] flen_tab  [MAX_SEGMENTS];
  logic [31:0]      fpos_tab  [MAX_SEGMENTS];
  logic [2:0]       perm_tab  [MAX_SEGMENTS];

  logic [ROW_BITS-1:0] bitmap [ROWS];
  logic [ROWS-1:0]     row_valid;

  logic [MAX_SEGMENTS-1:0] match_next;
  logic [MAX_SEGMENTS-1:0] match_vec;

  logic [SEG_W-1:0]    pick_idx;
  logic                pick_found;
  logic [31:0]         rel;
  logic [PIDX_W-1:0]   pidx;
  logic                page_ok;
  logic [PG_IDX_W-1:0] pg_idx;
  logic [ADDR_W-1:0]   rd_addr;

  logic [SEG_W-1:0]     hit_idx;
  logic                 hit_ok;
  logic [LEN_W-1:0]     off_q;
  logic [BIT_SEL_W-1:0] bit_sel_q;
  logic [ADDR_W-1:0]    row_addr_q;
  logic                 row_valid_q;
  logic [ROW_BITS-1:0]  rd_row;

  logic [ROW_BITS-1:0] cur_row;
  logic [ROW_BITS-1:0] new_row;
  logic                already;
  logic                map_new;
  logic [LEN_W:0]      off_end;
  logic [LEN_W-1:0]    flen;
  logic [LEN_W:0]      cp;
  logic [LEN_W:0]      zr;
  logic                slot_ok;
  logic [SEG_W-1:0]    wr_slot;

  dpfr_pkg::rsp_word_t load_word;
  dpfr_pkg::rsp_word_t fault_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
    end else if (cfg_wr) begin
      seg_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req_word;
    end
  end

  assign slot_ok = 32'(item.seg_slot) < MAX_SEGMENTS;
  assign wr_slot = SEG_W'(item.seg_slot);

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      base_tab[wr_slot] <= item.new_base;
      mlen_tab[wr_slot] <= item.new_mem_len;
      flen_tab[wr_slot] <= item.new_file_len;
      fpos_tab[wr_slot] <= item.new_file_pos;
      perm_tab[wr_slot] <= item.new_perm;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      match_next[i] = (5'(i) < {1'b0, seg_count})
                   && (item.miss_addr >= base_tab[i])
                   && ({1'b0, item.miss_addr} < ({1'b0, base_tab[i]} + 33'(mlen_tab[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      match_vec <= match_next;
    end
  end

  always_comb begin
    pick_idx   = '0;
    pick_found = 1'b0;
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        pick_idx   = SEG_W'(i);
        pick_found = 1'b1;
      end
    end
    rel     = item.miss_addr - base_tab[pick_idx];
    pidx    = rel[LEN_W-1:PAGE_SHIFT];
    page_ok = 32'(pidx) < MAX_PAGES;
    pg_idx  = PG_IDX_W'(pidx);
    rd_addr = {pick_idx, pg_idx[PG_IDX_W-1 -: ROW_SEL_W]};
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      hit_idx     <= pick_idx;
      hit_ok      <= pick_found && page_ok;
      off_q       <= {pidx, {PAGE_SHIFT{1'b0}}};
      bit_sel_q   <= pg_idx[BIT_SEL_W-1:0];
      row_addr_q  <= rd_addr;
      row_valid_q <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      rd_row <= bitmap[rd_addr];
    end
    if (cmd.commit && map_new) begin
      bitmap[row_addr_q] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.load && slot_ok) begin
      for (int r = 0; r < (1 << ROW_SEL_W); r++) begin
        row_valid[{wr_slot, ROW_SEL_W'(r)}] <= 1'b0;
      end
    end else if (cmd.commit && map_new) begin
      row_valid[row_addr_q] <= 1'b1;
    end
  end

  always_comb begin
    cur_row = row_valid_q ? rd_row : '0;
    already = cur_row[bit_sel_q];
    map_new = hit_ok && !already;
    new_row = cur_row | (ROW_BITS'(1) << bit_sel_q);
    flen    = flen_tab[hit_idx];
    off_end = {1'b0, off_q} + (LEN_W + 1)'(PAGE_BYTES);
    priority if (off_end <= {1'b0, flen}) begin
      cp = (LEN_W + 1)'(PAGE_BYTES);
    end else if (off_q < flen) begin
      cp = {1'b0, flen - off_q};
    end else begin
      cp = '0;
    end
    zr = (LEN_W + 1)'(PAGE_BYTES) - cp;
  end

  always_comb begin
    fault_word = '0;
    if (!hit_ok) begin
      fault_word.action = dpfr_pkg::ACT_NO_SEG;
    end else begin
      fault_word.hit_slot  = 3'(hit_idx);
      fault_word.page_addr = base_tab[hit_idx] + 32'(off_q);
      if (already) begin
        fault_word.action = dpfr_pkg::ACT_ALREADY;
      end else begin
        fault_word.action        = dpfr_pkg::ACT_MAPPED;
        fault_word.file_read_pos = fpos_tab[hit_idx] + 32'(off_q);
        fault_word.copy_bytes    = 13'(cp);
        fault_word.zero_bytes    = 13'(zr);
        fault_word.page_perm     = perm_tab[hit_idx];
      end
    end
  end

  always_comb begin
    load_word          = '0;
    load_word.action   = dpfr_pkg::ACT_STORED;
    load_word.hit_slot = item.seg_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load || cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_word <= load_word;
    end else if (cmd.commit) begin
      out_word <= fault_word;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(cmd.load || cmd.commit))
    else $error("pending result overwritten");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("stalled result not held");

  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && map_new) |=> row_valid[$past(row_addr_q)])
    else $error("bitmap row not marked valid after mapping");

endmodule

@@ src/demand_page_fault_resolver_unit.sv @@
// Top level of the demand page fault resolver: joins controller and
// datapath to the channels. Depends on dpfr_pkg, dpfr_if, dpfr_ctrl and
// dpfr_datapath.
//
//   channel  role     word
//   req      sink     load descriptor or page fault
//   rsp      source   action and page mapping details
//   cfg      sink     segment_count write, always ready
//
// A load word passes capture and load steps; a fault word passes capture,
// parallel range compare over the descriptor table, priority pick with bitmap
// row read and resolve with row write-back. The single-port bitmap
// read-modify-write sets the fault path. Reset clears segment_count, the
// result valid bit and the bitmap row valid bits at once; no clearing pass.
// A stalled rsp holds the result; the next word is taken while it waits,
// and its result waits in the load or resolve step.
module demand_page_fault_resolver_unit #(
  parameter int unsigned MAX_SEGMENTS = dpfr_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned PAGE_BYTES   = dpfr_pkg::PAGE_BYTES_DEF,
  parameter int unsigned MAX_PAGES    = dpfr_pkg::MAX_PAGES_DEF
) (
  input logic       clk,
  input logic       rst,
  dpfr_req_if.sink  req,
  dpfr_rsp_if.source rsp,
  dpfr_cfg_if.sink  cfg
);

  dpfr_pkg::cmd_t      cmd;
  dpfr_pkg::status_t   status;
  dpfr_pkg::req_word_t req_word;
  dpfr_pkg::rsp_word_t out_word;
  logic                out_valid;

  always_comb begin
    req_word.seg_slot     = req.seg_slot;
    req_word.new_base     = req.new_base;
    req_word.new_mem_len  = req.new_mem_len;
    req_word.new_file_len = req.new_file_len;
    req_word.new_file_pos = req.new_file_pos;
    req_word.new_perm     = req.new_perm;
    req_word.miss_addr    = req.miss_addr;
  end

  assign cfg.ready = 1'b1;

  dpfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_kind  (dpfr_pkg::kind_t'(req.kind)),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dpfr_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .PAGE_BYTES   (PAGE_BYTES),
    .MAX_PAGES    (MAX_PAGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_word  (req_word),
    .cfg_wr    (cfg.valid),
    .cfg_data  (cfg.data),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .out_word  (out_word)
  );

  assign rsp.valid         = out_valid;
  assign rsp.action        = out_word.action;
  assign rsp.hit_slot      = out_word.hit_slot;
  assign rsp.page_addr     = out_word.page_addr;
  assign rsp.file_read_pos = out_word.file_read_pos;
  assign rsp.copy_bytes    = out_word.copy_bytes;
  assign rsp.zero_bytes    = out_word.zero_bytes;
  assign rsp.page_perm     = out_word.page_perm;

endmodule
